@@ rtl/text_grid_layout_assert.svh @@
// ----------------------------------------------------------------------------
// text grid layout assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef TEXT_GRID_LAYOUT_ASSERT_SVH
`define TEXT_GRID_LAYOUT_ASSERT_SVH

`ifndef SYNTHESIS

`define TGL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("text_grid_layout: same-cycle check failed");

`define TGL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("text_grid_layout: next-cycle check failed");

`else

`define TGL_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define TGL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/tgl_pkg.sv @@
// ----------------------------------------------------------------------------
// tgl_pkg
// shared constants and types of the text grid layout block
// ----------------------------------------------------------------------------
`default_nettype none

package tgl_pkg;

	localparam int DEF_MAX_ROWS = 32;
	localparam int DEF_MAX_COLS = 128;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_CHAR  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] NULL_CODE    = 8'd0;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP      = 2'd2;

	localparam logic [5:0] ROW_COUNT_RST = 6'd32;
	localparam logic [7:0] COL_COUNT_RST = 8'd128;
	localparam logic       WRAP_RST      = 1'b1;

	typedef enum logic {
		CLR_IDLE,
		CLR_SWEEP
	} clr_state_t;

	// cursor position of a character write, wide enough for any grid size
	typedef struct packed {
		logic       placed;
		logic [7:0] row;
		logic [7:0] col;
	} place_t;

endpackage

`default_nettype wire

@@ rtl/tgl_ram.sv @@
// ----------------------------------------------------------------------------
// tgl_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tgl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/tgl_clear.sv @@
// ----------------------------------------------------------------------------
// tgl_clear
// sweeps the grid memory to zero after reset and on a start request
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_grid_layout_assert.svh"

module tgl_clear #(
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic [ADDR_W-1:0] addr
);

	import tgl_pkg::*;

	clr_state_t        state_q;
	clr_state_t        state_d;
	logic [ADDR_W-1:0] addr_q;
	logic              last;

	assign last = &addr_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CLR_IDLE: begin
				if (start) begin
					state_d = CLR_SWEEP;
				end
			end
			CLR_SWEEP: begin
				if (last) begin
					state_d = CLR_IDLE;
				end
			end
			default: state_d = CLR_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			CLR_SWEEP: busy = 1'b1;
			default:   busy = 1'b0;
		endcase
		addr = addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLR_SWEEP;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			if (busy) begin
				addr_q <= addr_q + ADDR_W'(1);
			end
		end
	end

	`TGL_ASSERT_IMP(a_idle_addr_home, clk, arst_n, state_q == CLR_IDLE, addr_q == '0)
	`TGL_ASSERT_NEXT(a_sweep_steps, clk, arst_n, busy && !last, busy && (addr_q == $past(addr_q) + ADDR_W'(1)))

endmodule

`default_nettype wire

@@ rtl/tgl_cursor.sv @@
// ----------------------------------------------------------------------------
// tgl_cursor
// layout cursor: row, column and line skip state, decides where a character goes
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_grid_layout_assert.svh"

module tgl_cursor #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            char_vld,
	input  logic [7:0]      char_in,
	input  logic [5:0]      row_count,
	input  logic [7:0]      col_count,
	input  logic            wrap_enable,
	output tgl_pkg::place_t place
);

	import tgl_pkg::*;

	localparam int ROW_W = $clog2(MAX_ROWS + 1);
	localparam int COL_W = $clog2(MAX_COLS);

	logic [ROW_W-1:0] cur_row_q;
	logic [ROW_W-1:0] cur_row_d;
	logic [COL_W-1:0] cur_col_q;
	logic [COL_W-1:0] cur_col_d;
	logic             skip_q;
	logic             skip_d;
	logic [8:0]       rows_eff;
	logic [8:0]       cols_ext;
	logic [8:0]       cols_eff;
	logic [8:0]       last;
	logic [8:0]       col_inc;
	logic             active;
	logic             full;

	always_comb begin
		rows_eff = (9'(row_count) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(row_count);
		cols_ext = 9'(col_count);
		if (cols_ext < 9'd2) begin
			cols_eff = 9'd2;
		end else if (cols_ext > 9'(MAX_COLS)) begin
			cols_eff = 9'(MAX_COLS);
		end else begin
			cols_eff = cols_ext;
		end
		last    = cols_eff - 9'd1;
		col_inc = 9'(cur_col_q) + 9'd1;
		active  = 9'(cur_row_q) < rows_eff;
	end

	always_comb begin
		cur_row_d = cur_row_q;
		cur_col_d = cur_col_q;
		skip_d    = skip_q;
		place     = '0;
		full      = 1'b0;
		if (start) begin
			cur_row_d = '0;
			cur_col_d = '0;
			skip_d    = 1'b0;
		end else if (char_vld && active) begin
			if (skip_q) begin
				if (char_in == NEWLINE_CODE) begin
					skip_d = 1'b0;
				end
			end else if (char_in == NEWLINE_CODE) begin
				cur_row_d = cur_row_q + ROW_W'(1);
				cur_col_d = '0;
			end else if (9'(cur_col_q) < last) begin
				place.placed = 1'b1;
				place.row    = 8'(cur_row_q);
				place.col    = 8'(cur_col_q);
				cur_col_d    = COL_W'(col_inc);
				full         = col_inc >= last;
			end else begin
				full = 1'b1;
			end
			if (full) begin
				if (!wrap_enable) begin
					skip_d = 1'b1;
				end
				cur_row_d = cur_row_q + ROW_W'(1);
				cur_col_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			skip_q    <= 1'b0;
		end else begin
			cur_row_q <= cur_row_d;
			cur_col_q <= cur_col_d;
			skip_q    <= skip_d;
		end
	end

	`TGL_ASSERT_IMP(a_col_below_last, clk, arst_n, 1'b1, 9'(cur_col_q) < 9'(MAX_COLS - 1))
	`TGL_ASSERT_NEXT(a_place_moves, clk, arst_n, place.placed, (cur_col_q != $past(cur_col_q)) || (cur_row_q != $past(cur_row_q)))

endmodule

`default_nettype wire

@@ rtl/text_grid_layout.sv @@
// ----------------------------------------------------------------------------
// text_grid_layout
// lays a character stream into a row by column grid held in one byte memory
// a result passes the request stage, then the output register; the grid read is
//   registered together with the request stage
// throughput: one item per cycle for character and read requests while the
//   output is not stalled; a start request, and reset, sweep the grid memory
//   one entry a cycle, all 2**ADDR_W entries (4096 by default), with input stalled
// reset clears cursor and pipeline valids and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_grid_layout_assert.svh"

module text_grid_layout #(
	parameter int MAX_ROWS = tgl_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = tgl_pkg::DEF_MAX_COLS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tgl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     req_type,
	input  logic [7:0]                     char_in,
	input  logic [4:0]                     read_row,
	input  logic [6:0]                     read_col,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     cell_value,
	output logic                           placed,
	output logic [4:0]                     place_row,
	output logic [6:0]                     place_col
);

	import tgl_pkg::*;

	localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_AW + COL_W;
	localparam int DEPTH  = 1 << ADDR_W;

	logic [5:0]        row_count_q;
	logic [7:0]        col_count_q;
	logic              wrap_q;
	logic              acc;
	logic              advance;
	logic              start;
	logic              char_vld;
	logic              rd_en;
	logic              clr_busy;
	logic [ADDR_W-1:0] clr_addr;
	place_t            place;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;
	logic              valid_s1;
	logic              rd_s1;
	logic              placed_s1;
	logic [4:0]        prow_s1;
	logic [6:0]        pcol_s1;
	logic              out_valid_q;
	logic [7:0]        cell_value_q;
	logic              placed_q;
	logic [4:0]        place_row_q;
	logic [6:0]        place_col_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
			wrap_q      <= WRAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW_COUNT: row_count_q <= cfg_data[5:0];
				CFG_COL_COUNT: col_count_q <= cfg_data[7:0];
				CFG_WRAP:      wrap_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = clr_busy || (valid_s1 && !advance);
	assign acc      = in_valid && !in_stall;
	assign start    = acc && (req_type == REQ_START);
	assign char_vld = acc && (req_type == REQ_CHAR);
	assign rd_en    = acc && (req_type == REQ_READ)
		&& (9'(read_row) < 9'(MAX_ROWS)) && (9'(read_col) < 9'(MAX_COLS));

	tgl_cursor #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_cursor (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.char_vld    (char_vld),
		.char_in     (char_in),
		.row_count   (row_count_q),
		.col_count   (col_count_q),
		.wrap_enable (wrap_q),
		.place       (place)
	);

	tgl_clear #(
		.ADDR_W (ADDR_W)
	) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	// sweep owns the write port while busy, input is stalled then
	always_comb begin
		ram_we    = clr_busy || place.placed;
		ram_waddr = clr_busy ? clr_addr
			: {place.row[ROW_AW-1:0], place.col[COL_W-1:0]};
		ram_wdata = clr_busy ? NULL_CODE : char_in;
		ram_raddr = {ROW_AW'(read_row), COL_W'(read_col)};
	end

	tgl_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// request stage, waits for the grid read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1     <= rd_en;
			placed_s1 <= place.placed;
			prow_s1   <= place.row[4:0];
			pcol_s1   <= place.col[6:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cell_value_q <= rd_s1 ? ram_rdata : NULL_CODE;
			placed_q     <= placed_s1;
			place_row_q  <= prow_s1;
			place_col_q  <= pcol_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = cell_value_q;
	assign placed     = placed_q;
	assign place_row  = place_row_q;
	assign place_col  = place_col_q;

	`TGL_ASSERT_IMP(a_sweep_stalls_input, clk, arst_n, clr_busy, in_stall)
	`TGL_ASSERT_IMP(a_placed_not_read, clk, arst_n, out_valid_q && placed_q, cell_value_q == NULL_CODE)

endmodule

`default_nettype wire

@@ sim/text_grid_layout_test.sv @@
// ----------------------------------------------------------------------------
// text_grid_layout_test
// drives character, read, start and unused requests into the grid layout
// block under many row, column and wrap settings; a scoreboard keeps its own
// copy of the grid and cursor, predicts the result of every item and checks
// each output item field by field, with random input gaps and output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module text_grid_layout_test;

	import tgl_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] cell_byte;
		logic       placed;
		logic [4:0] row;
		logic [6:0] col;
	} layout_result_t;

	class grid_scoreboard;
		logic [7:0] cells [DEF_MAX_ROWS][DEF_MAX_COLS];
		int cur_row;
		int cur_col;
		bit skipping;
		int row_cnt;
		int col_cnt;
		bit wrap_on;
		layout_result_t awaited [$];
		int errors;
		int requests;
		int checked;
		int placements;

		function new();
			clear_grid();
			row_cnt = int'(ROW_COUNT_RST);
			col_cnt = int'(COL_COUNT_RST);
			wrap_on = WRAP_RST;
			errors = 0;
			requests = 0;
			checked = 0;
			placements = 0;
		endfunction

		function void clear_grid();
			foreach (cells[r, c]) cells[r][c] = NULL_CODE;
			cur_row = 0;
			cur_col = 0;
			skipping = 1'b0;
		endfunction

		function int usable_rows();
			return (row_cnt > DEF_MAX_ROWS) ? DEF_MAX_ROWS : row_cnt;
		endfunction

		function int usable_cols();
			if (col_cnt < 2) return 2;
			if (col_cnt > DEF_MAX_COLS) return DEF_MAX_COLS;
			return col_cnt;
		endfunction

		function void advance_row();
			if (cur_row < usable_rows()) cur_row++;
			cur_col = 0;
		endfunction

		function void end_full_row();
			if (!wrap_on) skipping = 1'b1;
			advance_row();
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			case (idx)
				CFG_ROW_COUNT: row_cnt = int'(val[5:0]);
				CFG_COL_COUNT: col_cnt = int'(val);
				CFG_WRAP: wrap_on = val[0];
				default: ;
			endcase
		endfunction

		// predicts the layout result of one accepted item
		function void note_request(logic [1:0] rq, logic [7:0] ch, logic [4:0] rr,
				logic [6:0] rc);
			layout_result_t res;
			int last;
			res = '0;
			requests++;
			case (rq)
				REQ_START: clear_grid();
				REQ_CHAR: begin
					if (cur_row < usable_rows()) begin
						if (skipping) begin
							if (ch == NEWLINE_CODE) skipping = 1'b0;
						end else if (ch == NEWLINE_CODE) begin
							advance_row();
						end else begin
							last = usable_cols() - 1;
							if (cur_col < last) begin
								cells[cur_row][cur_col] = ch;
								res.placed = 1'b1;
								res.row = cur_row[4:0];
								res.col = cur_col[6:0];
								placements++;
								cur_col++;
								if (cur_col >= last) end_full_row();
							end else begin
								end_full_row();
							end
						end
					end
				end
				REQ_READ: res.cell_byte = cells[rr][rc];
				default: ;
			endcase
			awaited.push_back(res);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(layout_result_t got);
			layout_result_t want;
			if (awaited.size() == 0) begin
				$display("%0t: result with no item waiting, got cell %0d placed %0d at %0d,%0d",
					$time, got.cell_byte, got.placed, got.row, got.col);
				errors++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			compare_field("cell_value", want.cell_byte, got.cell_byte);
			compare_field("placed", want.placed, got.placed);
			compare_field("place_row", want.row, got.row);
			compare_field("place_col", want.col, got.col);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            req_type;
	logic [7:0]            char_in;
	logic [4:0]            read_row;
	logic [6:0]            read_col;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            cell_value;
	logic                  placed;
	logic [4:0]            place_row;
	logic [6:0]            place_col;

	grid_scoreboard sb = new();

	int gen_rows;
	int gen_cols;
	int line_left;
	int burst_left;
	int starts_left;
	int settings_used;
	bit hold_armed;
	bit hold_done;

	text_grid_layout dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.char_in(char_in),
		.read_row(read_row),
		.read_col(read_col),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cell_value(cell_value),
		.placed(placed),
		.place_row(place_row),
		.place_col(place_col)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 1000000);
		$display("text_grid_layout_test: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({cell_value, placed, place_row, place_col});
	end

	// output stall pattern, with one long hold-off once the random part runs
	initial begin
		int mode;
		int seg_len;
		int period;
		int duty;
		int k;
		out_stall <= 1'b0;
		forever begin
			if (hold_armed && !hold_done) begin
				for (k = 0; k < 400; k++) begin
					@(posedge clk);
					out_stall <= 1'b1;
				end
				hold_done = 1'b1;
			end
			mode = $urandom_range(0, 2);
			seg_len = $urandom_range(10, 60);
			period = $urandom_range(2, 8);
			duty = $urandom_range(1, period - 1);
			for (k = 0; k < seg_len; k++) begin
				@(posedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 2) == 0);
					default: out_stall <= ((k % period) < duty);
				endcase
			end
		end
	end

	task automatic offer_request(input logic [1:0] rq, input logic [7:0] ch,
			input logic [4:0] rr, input logic [6:0] rc);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		char_in <= ch;
		read_row <= rr;
		read_col <= rc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(rq, ch, rr, rc);
		burst_left--;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	task automatic apply_settings(input logic [5:0] rows, input logic [7:0] cols,
			input logic wrap);
		write_register(CFG_ROW_COUNT, {2'b00, rows});
		write_register(CFG_COL_COUNT, cols);
		write_register(CFG_WRAP, {7'd0, wrap});
		cfg_we <= 1'b0;
		gen_rows = (rows == 0) ? 1 : ((rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows);
		gen_cols = (cols < 2) ? 2 : ((cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cols);
		settings_used++;
	endtask

	task automatic offer_random_item();
		int pick;
		logic [7:0] ch;
		pick = $urandom_range(0, 99);
		if (pick == 0 && starts_left > 0) begin
			starts_left--;
			offer_request(REQ_START, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
				7'($urandom_range(0, 127)));
		end else if (pick < 3) begin
			offer_request(REQ_UNUSED, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
				7'($urandom_range(0, 127)));
		end else if (pick < 18) begin
			if ($urandom_range(0, 3) != 0)
				offer_request(REQ_READ, 8'($urandom_range(0, 255)),
					5'($urandom_range(0, gen_rows - 1)), 7'($urandom_range(0, gen_cols - 1)));
			else
				offer_request(REQ_READ, 8'($urandom_range(0, 255)),
					5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
		end else begin
			// lines of random length, mostly printable, some raw bytes
			if (line_left == 0) begin
				ch = NEWLINE_CODE;
				line_left = $urandom_range(0, gen_cols + gen_cols / 2);
			end else begin
				line_left--;
				ch = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(32, 126));
			end
			offer_request(REQ_CHAR, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
		end
	endtask

	initial begin
		logic [5:0] preset_rows [8];
		logic [7:0] preset_cols [8];
		logic       preset_wrap [8];
		int random_items;
		int phase;
		int count;
		int n;
		preset_rows = '{6'd63, 6'd0, 6'd1, 6'd32, 6'd3, 6'd33, 6'd2, 6'd5};
		preset_cols = '{8'd255, 8'd0, 8'd2, 8'd128, 8'd6, 8'd1, 8'd129, 8'd4};
		preset_wrap = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		gen_rows = DEF_MAX_ROWS;
		gen_cols = DEF_MAX_COLS;
		line_left = 0;
		burst_left = 0;
		starts_left = 30;
		settings_used = 0;
		hold_armed = 1'b0;
		hold_done = 1'b0;
		random_items = 0;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ROW_COUNT;
		cfg_data <= '0;
		in_valid <= 1'b0;
		req_type <= REQ_READ;
		char_in <= NULL_CODE;
		read_row <= '0;
		read_col <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: plain characters, byte extremes, reads, unused code, a start
		offer_request(REQ_READ, 8'h00, 5'd0, 7'd0);
		offer_request(REQ_CHAR, 8'h48, 5'd31, 7'd127);
		offer_request(REQ_CHAR, 8'hFF, 5'd0, 7'd0);
		offer_request(REQ_CHAR, NULL_CODE, 5'd0, 7'd0);
		offer_request(REQ_CHAR, NEWLINE_CODE, 5'd0, 7'd0);
		offer_request(REQ_CHAR, 8'h80, 5'd0, 7'd0);
		offer_request(REQ_READ, 8'hFF, 5'd0, 7'd1);
		offer_request(REQ_READ, 8'h00, 5'd31, 7'd127);
		offer_request(REQ_UNUSED, 8'hFF, 5'd31, 7'd127);
		offer_request(REQ_START, 8'h00, 5'd0, 7'd0);
		wait_drained();

		// two usable columns with wrap, newline right after a wrapped row
		apply_settings(6'd32, 8'd3, 1'b1);
		offer_request(REQ_CHAR, 8'h61, 5'd0, 7'd0);
		offer_request(REQ_CHAR, 8'h62, 5'd0, 7'd0);
		offer_request(REQ_CHAR, NEWLINE_CODE, 5'd0, 7'd0);
		offer_request(REQ_CHAR, 8'h63, 5'd0, 7'd0);
		offer_request(REQ_READ, 8'h00, 5'd2, 7'd0);
		wait_drained();

		// one row with truncation, then grid full
		apply_settings(6'd1, 8'd3, 1'b0);
		offer_request(REQ_START, 8'h00, 5'd0, 7'd0);
		offer_request(REQ_CHAR, 8'h78, 5'd0, 7'd0);
		offer_request(REQ_CHAR, 8'h79, 5'd0, 7'd0);
		offer_request(REQ_CHAR, 8'h7A, 5'd0, 7'd0);
		offer_request(REQ_CHAR, NEWLINE_CODE, 5'd0, 7'd0);
		wait_drained();

		// wrap turned on while skipping, out-of-range counts
		apply_settings(6'd63, 8'd0, 1'b1);
		offer_request(REQ_CHAR, 8'h71, 5'd0, 7'd0);
		offer_request(REQ_CHAR, NEWLINE_CODE, 5'd0, 7'd0);
		offer_request(REQ_CHAR, 8'h72, 5'd0, 7'd0);

		phase = 0;
		while (random_items < 830) begin
			wait_drained();
			if (phase < 8)
				apply_settings(preset_rows[phase], preset_cols[phase], preset_wrap[phase]);
			else
				apply_settings(
					6'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 6)
						: $urandom_range(0, 63)),
					8'(($urandom_range(0, 1) == 0) ? $urandom_range(2, 12)
						: $urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			if (starts_left > 0 && (phase == 0 || $urandom_range(0, 9) < 6)) begin
				starts_left--;
				offer_request(REQ_START, 8'($urandom_range(0, 255)),
					5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
				random_items++;
			end
			count = $urandom_range(40, 100);
			for (n = 0; n < count && random_items < 830; n++) begin
				offer_random_item();
				random_items++;
				if (random_items == 10) hold_armed = 1'b1;
			end
			phase++;
		end
		wait_drained();

		$display("run covered %0d items and %0d checked results, %0d characters placed",
			sb.requests, sb.checked, sb.placements);
		$display("%0d register settings used, long output hold-off %s",
			settings_used, hold_done ? "seen" : "not reached");
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("text_grid_layout_test: PASS");
		end else begin
			$display("text_grid_layout_test: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
